[design/fqd_pkg.sv]
// shared types and codes of the queue with discard
package fqd_pkg;

   localparam int DATA_WIDTH = 32;

   typedef logic [1:0] cmd_type;
   typedef logic [1:0] err_type;
   typedef logic signed [DATA_WIDTH-1:0] data_type;

   localparam cmd_type CMD_ENQUEUE = 2'd0;
   localparam cmd_type CMD_DEQUEUE = 2'd1;
   localparam cmd_type CMD_DISCARD = 2'd2;

   localparam err_type ERR_OK    = 2'd0;
   localparam err_type ERR_FULL  = 2'd1;
   localparam err_type ERR_EMPTY = 2'd2;
   localparam err_type ERR_RANGE = 2'd3;

endpackage

[design/fqd_slot_ram.sv]
// element store: one write port, one read port with registered read data
module fqd_slot_ram #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  fqd_pkg::data_type                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output fqd_pkg::data_type                 rd_data
);
   import fqd_pkg::*;

   data_type mem [DEPTH];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/fifo_queue_with_discard_top.sv]
// bounded queue of signed elements with enqueue, dequeue and discard at a position
//
// One command beat is taken at a rising edge where start is high and busy is low.
// Commands: enqueue appends req_value at the tail, dequeue drops the head,
// discard drops the element req_position places behind the head and closes the gap.
// Each command gives exactly one result beat, marked by rsp_valid for one cycle:
// head value, element count, empty flag and error code after the command.
// A failing command (full, empty, position out of range) changes nothing.
// Elements sit in a circular buffer in a single-port-write, registered-read memory.
// Enqueue, dequeue and failing commands pass through the head-read state to the
// result state; the next command may be accepted in the result cycle. A discard
// moves every later element up one entry, through one read state and one write
// state per element, and then reads the head; discarding the tail needs no shift.
// The memory's single read port paces both the shift and the head read.
// Reset clears the count and head pointer; element contents need no clearing.
// The receiver cannot stall; results must be taken in the cycle they appear.
module fifo_queue_with_discard_top #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  fqd_pkg::cmd_type                    req_command,
   input  fqd_pkg::data_type                   req_value,
   input  logic [$clog2(DEPTH)-1:0]            req_position,
   output logic                                rsp_valid,
   output fqd_pkg::data_type                   rsp_head_value,
   output logic [$clog2(DEPTH+1)-1:0]          rsp_count,
   output logic                                rsp_is_empty,
   output fqd_pkg::err_type                    rsp_error
);
   import fqd_pkg::*;

   localparam int AddrWidth = $clog2(DEPTH);
   localparam int CntWidth  = $clog2(DEPTH+1);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_SHIFT_RD = 5'b00010,
      ST_SHIFT_WR = 5'b00100,
      ST_HEAD_RD  = 5'b01000,
      ST_RESP     = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [AddrWidth-1:0]    head_ff, head_in;
   logic [CntWidth-1:0]     held_ff, held_in;
   logic [AddrWidth-1:0]    addr_ff, addr_in;
   logic [CntWidth-1:0]     rem_ff, rem_in;
   err_type                 err_ff, err_in;

   logic                    wr_en;
   logic [AddrWidth-1:0]    wr_addr;
   data_type                wr_data;
   logic [AddrWidth-1:0]    rd_addr;
   data_type                rd_data;

   logic                    accept;
   logic [CntWidth-1:0]     rem_new;

   function automatic logic [AddrWidth-1:0] wrap_add(input logic [AddrWidth-1:0] base,
                                                     input logic [AddrWidth-1:0] off);
      logic [AddrWidth:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (AddrWidth+1)'(DEPTH)) begin
         sum = sum - (AddrWidth+1)'(DEPTH);
      end
      return sum[AddrWidth-1:0];
   endfunction

   assign busy    = !(state_ff == ST_IDLE || state_ff == ST_RESP);
   assign accept  = start && !busy;
   assign rem_new = held_ff - CntWidth'(1) - CntWidth'(req_position);

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      held_in  = held_ff;
      addr_in  = addr_ff;
      rem_in   = rem_ff;
      err_in   = err_ff;
      wr_en    = 1'b0;
      wr_addr  = addr_ff;
      wr_data  = rd_data;
      rd_addr  = head_ff;

      case (state_ff)
         ST_IDLE, ST_RESP: begin
            if (accept) begin
               err_in   = ERR_OK;
               state_in = ST_HEAD_RD;
               case (req_command)
                  CMD_ENQUEUE: begin
                     if (held_ff == CntWidth'(DEPTH)) begin
                        err_in = ERR_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = wrap_add(head_ff, held_ff[AddrWidth-1:0]);
                        wr_data = req_value;
                        held_in = held_ff + CntWidth'(1);
                     end
                  end
                  CMD_DEQUEUE: begin
                     if (held_ff == '0) begin
                        err_in = ERR_EMPTY;
                     end else begin
                        head_in = wrap_add(head_ff, AddrWidth'(1));
                        held_in = held_ff - CntWidth'(1);
                     end
                  end
                  CMD_DISCARD: begin
                     if (held_ff == '0) begin
                        err_in = ERR_EMPTY;
                     end else if (CntWidth'(req_position) >= held_ff) begin
                        err_in = ERR_RANGE;
                     end else begin
                        addr_in = wrap_add(head_ff, req_position);
                        rem_in  = rem_new;
                        if (rem_new == '0) begin
                           held_in = held_ff - CntWidth'(1);
                        end else begin
                           state_in = ST_SHIFT_RD;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT_RD: begin
            rd_addr  = wrap_add(addr_ff, AddrWidth'(1));
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            wr_data = rd_data;
            addr_in = wrap_add(addr_ff, AddrWidth'(1));
            rem_in  = rem_ff - CntWidth'(1);
            if (rem_ff == CntWidth'(1)) begin
               held_in  = held_ff - CntWidth'(1);
               state_in = ST_HEAD_RD;
            end else begin
               state_in = ST_SHIFT_RD;
            end
         end
         ST_HEAD_RD: begin
            state_in = ST_RESP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         held_ff  <= '0;
         err_ff   <= ERR_OK;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         held_ff  <= held_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rem_ff  <= rem_in;
   end

   fqd_slot_ram #(
      .DEPTH(DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid      = (state_ff == ST_RESP);
   assign rsp_head_value = (held_ff == '0) ? '0 : rd_data;
   assign rsp_count      = held_ff;
   assign rsp_is_empty   = (held_ff == '0);
   assign rsp_error      = err_ff;

endmodule

[design/fqd_checker.sv]
// port-level checks for the queue with discard, bound to the top level
module fqd_checker #(
   parameter int DEPTH = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input fqd_pkg::data_type                   rsp_head_value,
   input logic [$clog2(DEPTH+1)-1:0]          rsp_count,
   input logic                                rsp_is_empty,
   input fqd_pkg::err_type                    rsp_error
);
   import fqd_pkg::*;

   localparam int CntWidth = $clog2(DEPTH+1);

   // an accepted command always makes the block busy in the cycle after it is taken
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("no busy cycle after an accepted command");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_head_value == '0)
      else $error("head value not zero on empty queue");

   a_full_error_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error == ERR_FULL |-> rsp_count == CntWidth'(DEPTH))
      else $error("full error reported below capacity");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= CntWidth'(DEPTH))
      else $error("count above capacity");

endmodule

bind fifo_queue_with_discard_top fqd_checker #(
   .DEPTH(DEPTH)
) u_fqd_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_head_value (rsp_head_value),
   .rsp_count      (rsp_count),
   .rsp_is_empty   (rsp_is_empty),
   .rsp_error      (rsp_error)
);
